// File: sv/rgb2hsv_pkg.sv
// Package for the RGB to HSV converter: widths, hue sector constants and
// the restoring division step shared by the pipelined dividers.
// Depends on nothing.
package rgb2hsv_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned HUE_W         = 13;
  localparam int unsigned HUE_Q_W       = 10;
  localparam int unsigned SAT_Q_W       = 8;
  localparam int unsigned HUE_NUM_W     = CHAN_W + HUE_Q_W;
  localparam int unsigned SAT_NUM_W     = CHAN_W + SAT_Q_W;
  localparam int unsigned STEPS_PER_STG = 2;
  localparam int unsigned DIV_STAGES    = (HUE_Q_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int unsigned LATENCY       = DIV_STAGES + 3;

  localparam logic [HUE_W:0] HUE_SECTOR_RED   = 14'd0;
  localparam logic [HUE_W:0] HUE_SECTOR_GREEN = 14'd1920;
  localparam logic [HUE_W:0] HUE_SECTOR_BLUE  = 14'd3840;
  localparam logic [HUE_W:0] HUE_FULL_TURN    = 14'd5760;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic              qbit;
    logic [CHAN_W-1:0] rem;
  } div_step_t;

  // One step of restoring division: shift in a numerator bit, subtract if it fits.
  function automatic div_step_t div_step(input logic [CHAN_W-1:0] rem,
                                         input logic [CHAN_W-1:0] den,
                                         input logic              nbit);
    logic [CHAN_W:0] trial;
    logic [CHAN_W:0] diff;
    div_step_t       res;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      res.qbit = 1'b1;
      res.rem  = diff[CHAN_W-1:0];
    end else begin
      res.qbit = 1'b0;
      res.rem  = trial[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [HUE_W:0] sector_offset(input sector_t sec);
    logic [HUE_W:0] off;
    unique case (sec)
      SECTOR_GREEN: off = HUE_SECTOR_GREEN;
      SECTOR_BLUE:  off = HUE_SECTOR_BLUE;
      default:      off = HUE_SECTOR_RED;
    endcase
    return off;
  endfunction

endpackage

// File: sv/rgb_to_hsv_converter_core.sv
// RGB to HSV converter top level: a pipeline of channel compare, numerator
// forming, two radix-2 dividers at two bits per stage, and hue assembly.
// Depends on rgb2hsv_pkg.
//
// Usage: a request carries one 8-bit pixel on red_in, green_in and blue_in
// and is taken at a rising edge where start is high and busy is low. busy is
// high only while rst is high, so a new pixel may be given every cycle.
// Each result appears on hue_out, saturation_out and value_out for exactly
// one cycle with done high. hue_out is in sixteenths of a degree (0..5759),
// saturation_out is floor(255*(max-min)/max) and value_out is the largest
// channel.
// Stages from the accepting edge to the cycle with done high:
// one stage for max/min and sector choice, one for the numerators, five for
// the dividers (two quotient bits per stage, ten hue bits) and one for the
// hue sector offset and wrap. Throughput is one pixel per clock outside reset.
// A synchronous reset clears every valid bit, so requests in flight are
// dropped and done stays low until new pixels arrive. The receiver cannot
// stall; results are never held back.
module rgb_to_hsv_converter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]   red_in,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]   green_in,
  input  logic [rgb2hsv_pkg::CHAN_W-1:0]   blue_in,
  output logic                             done,
  output logic [rgb2hsv_pkg::HUE_W-1:0]    hue_out,
  output logic [rgb2hsv_pkg::CHAN_W-1:0]   saturation_out,
  output logic [rgb2hsv_pkg::CHAN_W-1:0]   value_out
);
  import rgb2hsv_pkg::*;

  // Stage 1: max, min, sector and signed difference.
  logic              s1_valid;
  logic [CHAN_W-1:0] s1_max;
  logic [CHAN_W-1:0] s1_delta;
  logic [CHAN_W-1:0] s1_mag;
  logic              s1_neg;
  sector_t           s1_sector;

  logic [CHAN_W-1:0] mx, mn;
  logic [CHAN_W:0]   sdiff;
  logic [CHAN_W:0]   sdiff_abs;
  sector_t           sector;

  always_comb begin
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx)  mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn)  mn = blue_in;
    priority if (red_in >= green_in && red_in >= blue_in) begin
      sector = SECTOR_RED;
      sdiff  = {1'b0, green_in} - {1'b0, blue_in};
    end else if (green_in >= blue_in) begin
      sector = SECTOR_GREEN;
      sdiff  = {1'b0, blue_in} - {1'b0, red_in};
    end else begin
      sector = SECTOR_BLUE;
      sdiff  = {1'b0, red_in} - {1'b0, green_in};
    end
    sdiff_abs = sdiff[CHAN_W] ? (~sdiff + 1'b1) : sdiff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_max    <= mx;
    s1_delta  <= mx - mn;
    s1_mag    <= sdiff_abs[CHAN_W-1:0];
    s1_neg    <= sdiff[CHAN_W];
    s1_sector <= sector;
  end

  // Stage 2 and divider stages share arrays: index 0 is the numerator stage.
  logic              d_valid  [DIV_STAGES+1];
  logic [CHAN_W-1:0] d_max    [DIV_STAGES+1];
  logic [CHAN_W-1:0] d_delta  [DIV_STAGES+1];
  logic              d_neg    [DIV_STAGES+1];
  sector_t           d_sector [DIV_STAGES+1];
  logic [CHAN_W-1:0] d_hrem   [DIV_STAGES+1];
  logic [HUE_Q_W-1:0] d_hq    [DIV_STAGES+1];
  logic [CHAN_W-1:0] d_srem   [DIV_STAGES+1];
  logic [SAT_Q_W-1:0] d_sq    [DIV_STAGES+1];

  logic [HUE_NUM_W-1:0] hue_num;
  logic [SAT_NUM_W-1:0] sat_num;

  assign hue_num = {s1_mag, {HUE_Q_W{1'b0}}}
                 - {{(HUE_Q_W-6){1'b0}}, s1_mag, 6'd0};
  assign sat_num = {s1_delta, {SAT_Q_W{1'b0}}} - {{SAT_Q_W{1'b0}}, s1_delta};

  logic [CHAN_W-1:0]  hrem_next [DIV_STAGES];
  logic [HUE_Q_W-1:0] hq_next   [DIV_STAGES];
  logic [CHAN_W-1:0]  srem_next [DIV_STAGES];
  logic [SAT_Q_W-1:0] sq_next   [DIV_STAGES];

  always_comb begin
    div_step_t hs;
    div_step_t ss;
    hs = '0;
    ss = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      hrem_next[s] = d_hrem[s];
      hq_next[s]   = d_hq[s];
      srem_next[s] = d_srem[s];
      sq_next[s]   = d_sq[s];
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        if (s * STEPS_PER_STG + j < HUE_Q_W) begin
          hs           = div_step(hrem_next[s], d_delta[s], hq_next[s][HUE_Q_W-1]);
          hrem_next[s] = hs.rem;
          hq_next[s]   = {hq_next[s][HUE_Q_W-2:0], hs.qbit};
        end
        if (s * STEPS_PER_STG + j < SAT_Q_W) begin
          ss           = div_step(srem_next[s], d_max[s], sq_next[s][SAT_Q_W-1]);
          srem_next[s] = ss.rem;
          sq_next[s]   = {sq_next[s][SAT_Q_W-2:0], ss.qbit};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else begin
      d_valid[0] <= s1_valid;
    end
    d_max[0]    <= s1_max;
    d_delta[0]  <= s1_delta;
    d_neg[0]    <= s1_neg;
    d_sector[0] <= s1_sector;
    d_hrem[0]   <= hue_num[HUE_NUM_W-1:HUE_Q_W];
    d_hq[0]     <= hue_num[HUE_Q_W-1:0];
    d_srem[0]   <= sat_num[SAT_NUM_W-1:SAT_Q_W];
    d_sq[0]     <= sat_num[SAT_Q_W-1:0];
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rst) begin
        d_valid[s+1] <= 1'b0;
      end else begin
        d_valid[s+1] <= d_valid[s];
      end
      d_max[s+1]    <= d_max[s];
      d_delta[s+1]  <= d_delta[s];
      d_neg[s+1]    <= d_neg[s];
      d_sector[s+1] <= d_sector[s];
      d_hrem[s+1]   <= hrem_next[s];
      d_hq[s+1]     <= hq_next[s];
      d_srem[s+1]   <= srem_next[s];
      d_sq[s+1]     <= sq_next[s];
    end
  end

  // Last stage: floor correction for negative differences, offset, wrap, grey/black zeros.
  logic [HUE_Q_W:0] hmag;
  logic [HUE_W:0]   hoff;
  logic [HUE_W:0]   hue_next;
  logic [CHAN_W-1:0] sat_next;

  always_comb begin
    hmag = {1'b0, d_hq[DIV_STAGES]}
         + {{HUE_Q_W{1'b0}}, (d_neg[DIV_STAGES] && d_hrem[DIV_STAGES] != '0)};
    hoff = sector_offset(d_sector[DIV_STAGES]);
    priority if (d_delta[DIV_STAGES] == '0) begin
      hue_next = '0;
    end else if (!d_neg[DIV_STAGES]) begin
      hue_next = hoff + {{(HUE_W-HUE_Q_W){1'b0}}, hmag};
    end else if (hoff >= {{(HUE_W-HUE_Q_W){1'b0}}, hmag}) begin
      hue_next = hoff - {{(HUE_W-HUE_Q_W){1'b0}}, hmag};
    end else begin
      hue_next = hoff + HUE_FULL_TURN - {{(HUE_W-HUE_Q_W){1'b0}}, hmag};
    end
    sat_next = (d_max[DIV_STAGES] == '0) ? '0 : d_sq[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid[DIV_STAGES];
    end
    hue_out        <= hue_next[HUE_W-1:0];
    saturation_out <= sat_next;
    value_out      <= d_max[DIV_STAGES];
  end

  assign busy = rst;

endmodule

// File: sv/rgb2hsv_checker.sv
// Port checker for the RGB to HSV converter, bound to the top level.
// Depends on rgb2hsv_pkg and rgb_to_hsv_converter_core.
module rgb2hsv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [rgb2hsv_pkg::HUE_W-1:0]  hue_out,
  input logic [rgb2hsv_pkg::CHAN_W-1:0] saturation_out,
  input logic [rgb2hsv_pkg::CHAN_W-1:0] value_out
);
  import rgb2hsv_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done)
    else $error("A request did not produce a result after eight cycles.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8))
    else $error("A result appeared without a matching request.");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue_out < 13'd5760)
    else $error("Hue is outside its range.");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && value_out == '0) |-> (hue_out == '0 && saturation_out == '0))
    else $error("A black pixel gave non-zero hue or saturation.");

endmodule

bind rgb_to_hsv_converter_core rgb2hsv_checker u_rgb2hsv_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .hue_out        (hue_out),
  .saturation_out (saturation_out),
  .value_out      (value_out)
);

// File: bench/rgb_to_hsv_converter_core_tb.sv
// Self-checking testbench for rgb_to_hsv_converter_core: directed and random pixels,
// each result compared with an in-bench fixed-point HSV predictor.
// Depends on rgb2hsv_pkg and the converter RTL.
module rgb_to_hsv_converter_core_tb;
  import rgb2hsv_pkg::*;

  localparam int HALF_SECTOR = 960;
  localparam int GREEN_BASE  = 1920;
  localparam int BLUE_BASE   = 3840;
  localparam int FULL_TURN   = 5760;
  localparam int FULL_SCALE  = 255;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
  } hsv_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              start          = 1'b0;
  logic [CHAN_W-1:0] red_in         = '0;
  logic [CHAN_W-1:0] green_in       = '0;
  logic [CHAN_W-1:0] blue_in        = '0;
  logic              busy;
  logic              done;
  logic [HUE_W-1:0]  hue_out;
  logic [CHAN_W-1:0] saturation_out;
  logic [CHAN_W-1:0] value_out;

  hsv_t expected_hsv_q[$];
  int   err_count = 0;

  rgb_to_hsv_converter_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .red_in         (red_in),
    .green_in       (green_in),
    .blue_in        (blue_in),
    .done           (done),
    .hue_out        (hue_out),
    .saturation_out (saturation_out),
    .value_out      (value_out)
  );

  always #10 clk = ~clk;

  function automatic hsv_t predict_hsv(input logic [CHAN_W-1:0] r,
                                       input logic [CHAN_W-1:0] g,
                                       input logic [CHAN_W-1:0] b);
    int   ri;
    int   gi;
    int   bi;
    int   mx;
    int   mn;
    int   delta;
    int   diff;
    int   base;
    int   share;
    int   hue;
    int   sat;
    hsv_t res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (mx != 0) begin
      sat = (FULL_SCALE * delta) / mx;
      if (delta != 0) begin
        if (ri == mx) begin
          base = 0;
          diff = gi - bi;
        end else if (gi == mx) begin
          base = GREEN_BASE;
          diff = bi - ri;
        end else begin
          base = BLUE_BASE;
          diff = ri - gi;
        end
        // The hue share is floored, so a negative share rounds away from zero.
        if (diff >= 0) begin
          share = (HALF_SECTOR * diff) / delta;
        end else begin
          share = -((HALF_SECTOR * (-diff) + delta - 1) / delta);
        end
        hue = base + share;
        if (hue < 0) hue = hue + FULL_TURN;
      end
    end
    res.hue = hue[HUE_W-1:0];
    res.sat = sat[CHAN_W-1:0];
    res.val = mx[CHAN_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pixel(input logic [CHAN_W-1:0] r,
                            input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b,
                            input int gap);
    start    <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (busy);
    expected_hsv_q.push_back(predict_hsv(r, g, b));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    hsv_t want;
    if (!rst && done) begin
      if (expected_hsv_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                  hue_out, saturation_out, value_out));
      end else begin
        want = expected_hsv_q.pop_front();
        if (hue_out !== want.hue)
          report_mismatch($sformatf("hue %0d, wanted %0d", hue_out, want.hue));
        if (saturation_out !== want.sat)
          report_mismatch($sformatf("saturation %0d, wanted %0d", saturation_out, want.sat));
        if (value_out !== want.val)
          report_mismatch($sformatf("value %0d, wanted %0d", value_out, want.val));
      end
    end
  end

  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0,   0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 1);
    send_pixel(8'd1,   8'd1,   8'd1,   0);
    send_pixel(8'd255, 8'd0,   8'd0,   0);
    send_pixel(8'd0,   8'd255, 8'd0,   2);
    send_pixel(8'd0,   8'd0,   8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0,   0);
    send_pixel(8'd0,   8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd0,   8'd255, 3);
    send_pixel(8'd255, 8'd0,   8'd1,   0);
    send_pixel(8'd255, 8'd1,   8'd0,   0);
    send_pixel(8'd1,   8'd0,   8'd0,   0);
    send_pixel(8'd0,   8'd0,   8'd1,   1);
    send_pixel(8'd255, 8'd254, 8'd0,   0);
    send_pixel(8'd254, 8'd0,   8'd255, 0);
    send_pixel(8'd0,   8'd255, 8'd1,   0);
    send_pixel(8'd1,   8'd255, 8'd0,   0);
    send_pixel(8'd0,   8'd1,   8'd255, 5);
    send_pixel(8'd1,   8'd0,   8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd254, 0);
    send_pixel(8'd2,   8'd1,   8'd3,   0);
    wait_for_results();
  endtask

  task automatic test_random_uniform(input int count);
    repeat (count) begin
      send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), pick_gap());
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) begin
      send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), 0);
    end
  endtask

  task automatic test_random_shaped(input int count);
    int                mode;
    int                hi;
    int                lo;
    int                ch[3];
    logic [CHAN_W-1:0] edge_vals[4];
    edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
    repeat (count) begin
      mode = $urandom_range(0, 5);
      case (mode)
        0: begin
          hi = $urandom_range(0, 255);
          ch = '{hi, hi, hi};
        end
        1: begin
          hi = $urandom_range(0, 255);
          lo = $urandom_range(0, hi);
          case ($urandom_range(0, 2))
            0:       ch = '{hi, hi, lo};
            1:       ch = '{hi, lo, hi};
            default: ch = '{lo, hi, hi};
          endcase
        end
        2: begin
          lo = $urandom_range(0, 255);
          foreach (ch[i]) begin
            ch[i] = lo + $urandom_range(0, 4);
            if (ch[i] > 255) ch[i] = 255;
          end
        end
        3: begin
          foreach (ch[i]) ch[i] = int'(edge_vals[$urandom_range(0, 3)]);
        end
        default: begin
          foreach (ch[i]) ch[i] = $urandom_range(0, 255);
        end
      endcase
      send_pixel(ch[0][CHAN_W-1:0], ch[1][CHAN_W-1:0], ch[2][CHAN_W-1:0], pick_gap());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_uniform(400);
    wait_for_results();
    test_back_to_back(150);
    test_random_shaped(350);
    wait_for_results();
    test_random_uniform(100);
    test_random_shaped(250);
    wait_for_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (err_count == 0) begin
      $display("rgb_to_hsv_converter_core_tb: PASS");
    end else begin
      $display("rgb_to_hsv_converter_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("rgb_to_hsv_converter_core_tb: FAIL");
    $finish;
  end

endmodule

// File: rgb_to_hsv_converter_core.f
sv/rgb2hsv_pkg.sv
sv/rgb_to_hsv_converter_core.sv
sv/rgb2hsv_checker.sv
bench/rgb_to_hsv_converter_core_tb.sv
